[sv/fbc_pkg.sv]
package fbc_pkg;

  localparam int DATA_W     = 32;
  localparam int COEF_W     = DATA_W + 1;
  localparam int PROD_W     = COEF_W + DATA_W;
  localparam int IDX_W      = 4;
  localparam int NUM_ENTRY  = 16;
  localparam int NUM_PLANE  = 6;
  localparam int NUM_AXIS   = 3;
  localparam int NUM_COL    = 4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

endpackage

[sv/frustum_box_cull.sv]
// Box-against-frustum cull. Load requests write one of the 16 view-projection
// matrix entries (row*4 + column, Q16.16) and return nothing; a write is seen
// by every test request accepted after it. Test requests carry the min and max
// corners of a box (a point is a box with equal corners) and return one flag,
// inside_res = 0 when any of the six clip planes (row 3 plus or minus rows 0..2)
// puts the box's furthest corner at a negative distance. The arithmetic is
// exact, with no rounding or saturation. One request is taken every cycle while
// req_stall is low. Plane coefficients, the 18 parallel 33x32 corner products,
// two rounds of wide adds and the output register each take one stage. res_stall
// only holds back the stages that are full, so requests keep flowing into empty
// stages behind a waiting result.
module frustum_box_cull #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             operation,
  input  logic [fbc_pkg::IDX_W-1:0]        entry_index,
  input  logic signed [fbc_pkg::DATA_W-1:0] entry_value,
  input  logic signed [fbc_pkg::DATA_W-1:0] box_min_x,
  input  logic signed [fbc_pkg::DATA_W-1:0] box_min_y,
  input  logic signed [fbc_pkg::DATA_W-1:0] box_min_z,
  input  logic signed [fbc_pkg::DATA_W-1:0] box_max_x,
  input  logic signed [fbc_pkg::DATA_W-1:0] box_max_y,
  input  logic signed [fbc_pkg::DATA_W-1:0] box_max_z,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic                             inside_res
);

  localparam int SHIFT_W = fbc_pkg::COEF_W + FRACTION_BITS;
  localparam int WIDE_W  = (SHIFT_W > fbc_pkg::PROD_W) ? SHIFT_W : fbc_pkg::PROD_W;
  localparam int S3_W    = WIDE_W + 1;
  localparam int TOT_W   = S3_W + 1;

  logic signed [fbc_pkg::DATA_W-1:0] matrix [fbc_pkg::NUM_ENTRY];

  logic signed [fbc_pkg::COEF_W-1:0] coef_next [fbc_pkg::NUM_PLANE][fbc_pkg::NUM_COL];
  logic signed [fbc_pkg::DATA_W-1:0] corner [fbc_pkg::NUM_PLANE][fbc_pkg::NUM_AXIS];
  logic signed [TOT_W-1:0]           total [fbc_pkg::NUM_PLANE];
  logic [fbc_pkg::NUM_PLANE-1:0]     reject_next;

  logic                              s1_valid;
  logic signed [fbc_pkg::COEF_W-1:0] s1_coef [fbc_pkg::NUM_PLANE][fbc_pkg::NUM_COL];
  logic signed [fbc_pkg::DATA_W-1:0] s1_min [fbc_pkg::NUM_AXIS];
  logic signed [fbc_pkg::DATA_W-1:0] s1_max [fbc_pkg::NUM_AXIS];

  logic                              s2_valid;
  logic signed [fbc_pkg::PROD_W-1:0] s2_prod [fbc_pkg::NUM_PLANE][fbc_pkg::NUM_AXIS];
  logic signed [SHIFT_W-1:0]         s2_dsh [fbc_pkg::NUM_PLANE];

  logic                              s3_valid;
  logic signed [S3_W-1:0]            s3_sum_a [fbc_pkg::NUM_PLANE];
  logic signed [S3_W-1:0]            s3_sum_b [fbc_pkg::NUM_PLANE];

  logic                              s4_valid;
  logic [fbc_pkg::NUM_PLANE-1:0]     s4_reject;

  logic en0, en1, en2, en3, en4;
  logic accept;
  logic is_test;

  // stage enables: a stage moves when it is empty or the next one moves
  assign en4 = !res_valid || !res_stall;
  assign en3 = !s4_valid || en4;
  assign en2 = !s3_valid || en3;
  assign en1 = !s2_valid || en2;
  assign en0 = !s1_valid || en1;

  assign req_stall = !en0;
  assign accept    = req_valid && en0;
  assign is_test   = (operation == fbc_pkg::OP_TEST);

  // matrix entries
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbc_pkg::NUM_ENTRY; i++) begin
        matrix[i] <= '0;
      end
    end else if (accept && (operation == fbc_pkg::OP_LOAD)) begin
      matrix[entry_index] <= entry_value;
    end
  end

  // plane coefficients: row 3 plus or minus row 0, 1, 2
  always_comb begin
    for (int p = 0; p < fbc_pkg::NUM_PLANE; p++) begin
      for (int c = 0; c < fbc_pkg::NUM_COL; c++) begin
        if ((p & 1) != 0) begin
          coef_next[p][c] =
            fbc_pkg::COEF_W'(matrix[fbc_pkg::IDX_W'(3 * fbc_pkg::NUM_COL + c)])
            - fbc_pkg::COEF_W'(matrix[fbc_pkg::IDX_W'((p >> 1) * fbc_pkg::NUM_COL + c)]);
        end else begin
          coef_next[p][c] =
            fbc_pkg::COEF_W'(matrix[fbc_pkg::IDX_W'(3 * fbc_pkg::NUM_COL + c)])
            + fbc_pkg::COEF_W'(matrix[fbc_pkg::IDX_W'((p >> 1) * fbc_pkg::NUM_COL + c)]);
        end
      end
    end
  end

  // furthest corner along each plane normal
  always_comb begin
    for (int p = 0; p < fbc_pkg::NUM_PLANE; p++) begin
      for (int k = 0; k < fbc_pkg::NUM_AXIS; k++) begin
        if (!s1_coef[p][k][fbc_pkg::COEF_W-1] && (s1_coef[p][k] != '0)) begin
          corner[p][k] = s1_max[k];
        end else begin
          corner[p][k] = s1_min[k];
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < fbc_pkg::NUM_PLANE; p++) begin
      total[p] = TOT_W'(s3_sum_a[p]) + TOT_W'(s3_sum_b[p]);
      reject_next[p] = total[p][TOT_W-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en0) begin
        s1_valid <= accept && is_test;
      end
      if (en1) begin
        s2_valid <= s1_valid;
      end
      if (en2) begin
        s3_valid <= s2_valid;
      end
      if (en3) begin
        s4_valid <= s3_valid;
      end
      if (en4) begin
        res_valid <= s4_valid;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en0) begin
      s1_coef   <= coef_next;
      s1_min[0] <= box_min_x;
      s1_min[1] <= box_min_y;
      s1_min[2] <= box_min_z;
      s1_max[0] <= box_max_x;
      s1_max[1] <= box_max_y;
      s1_max[2] <= box_max_z;
    end
    if (en1) begin
      for (int p = 0; p < fbc_pkg::NUM_PLANE; p++) begin
        for (int k = 0; k < fbc_pkg::NUM_AXIS; k++) begin
          s2_prod[p][k] <= s1_coef[p][k] * corner[p][k];
        end
        s2_dsh[p] <= SHIFT_W'(s1_coef[p][3]) <<< FRACTION_BITS;
      end
    end
    if (en2) begin
      for (int p = 0; p < fbc_pkg::NUM_PLANE; p++) begin
        s3_sum_a[p] <= S3_W'(s2_prod[p][0]) + S3_W'(s2_prod[p][1]);
        s3_sum_b[p] <= S3_W'(s2_prod[p][2]) + S3_W'(s2_dsh[p]);
      end
    end
    if (en3) begin
      s4_reject <= reject_next;
    end
    if (en4) begin
      inside_res <= !(|s4_reject);
    end
  end

endmodule

[sv/fbc_check.sv]
module fbc_check (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic res_valid,
  input logic res_stall,
  input logic inside_res
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && !req_stall)
    else $error("result or stall right after reset");

  // requests are only held back when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (res_valid && res_stall))
    else $error("request stalled with no waiting result");

  // a held request stays stalled until the result is taken
  a_stall_chain: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_stall && res_valid && res_stall) ##1 (res_stall && !rst)
      |-> req_stall)
    else $error("full pipeline released without result being taken");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(inside_res)))
    else $error("stalled result changed");

endmodule

bind frustum_box_cull fbc_check u_fbc_check (.*);
